// ===== hdl/volume_nonmax_suppression_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the volume non-maximum suppression block
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef VOLUME_NONMAX_SUPPRESSION_ASSERT_SVH
`define VOLUME_NONMAX_SUPPRESSION_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define VNMS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define VNMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/vnms_pkg.sv =====
// ----------------------------------------------------------------------------
// vnms_pkg
// Types, constants and helper functions shared by the controller and the
// datapath of the volume non-maximum suppression block.
// ----------------------------------------------------------------------------
package vnms_pkg;

  // Field widths
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned IDX_W  = 18;
  localparam int unsigned NRM_W  = 16;
  localparam int unsigned IN_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Size register limits
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  // Item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Fixed point: 0.71 in Q0.15, rounding half, one in Q0.15
  localparam int unsigned WEIGHT_Q15 = 23265;
  localparam int unsigned HALF_Q15   = 16384;
  localparam int unsigned ONE_Q15    = 32768;
  localparam int unsigned Q_SHIFT    = 15;
  localparam int unsigned CENTRE_SHIFT = 30;

  // Signed address arithmetic: index plus slice stride plus row stride
  localparam int unsigned ADDR_CALC_W = 27;
  localparam int unsigned STRIDE_W    = 2 * SIZE_W;

  // Sequencer counts
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned DIV_LAST = IDX_W - 1;
  localparam int unsigned RD_LAST  = 15;
  localparam int unsigned RD_SEL_W = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_CHECK,
    ST_READ,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic                mem_write;
    logic                capture;
    logic                div_step;
    logic                div_y;
    logic                div_load_y;
    logic                div_done;
    logic                rd_en;
    logic [RD_SEL_W-1:0] rd_sel;   // {backward, dz, dy, dx}
    logic                publish;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic border;
    logic pipe_idle;
    logic out_free;
  } dp_status_t;

  // Tag that travels with each corner through the interpolation pipeline
  typedef struct packed {
    logic v;
    logic dir;
    logic dz;
    logic dy;
    logic dx;
    logic inr;
  } tap_t;

  // Clamp a written size into its legal range
  function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < SIZE_MIN) r = SIZE_MIN;
    else if (v > SIZE_MAX) r = SIZE_MAX;
    return r;
  endfunction

  // Axis weight: round(0.71 * |n|) in Q0.15
  function automatic logic [15:0] weight_q15(logic signed [NRM_W-1:0] n);
    logic [NRM_W:0] mag;
    logic [31:0]    prod;
    mag  = n[NRM_W-1] ? (17'd0 - {n[NRM_W-1], n}) : {1'b0, n};
    prod = 32'(mag) * 32'(WEIGHT_Q15) + 32'(HALF_Q15);
    return prod[30:15];
  endfunction

  // Lerp factor for the near (1 - k) or far (k) sample
  function automatic logic signed [16:0] lerp_w(logic far, logic [15:0] k);
    logic [16:0] one;
    one = 17'(ONE_Q15);
    return far ? signed'({1'b0, k}) : signed'(one - {1'b0, k});
  endfunction

endpackage

// ===== hdl/vnms_ctrl.sv =====
// ----------------------------------------------------------------------------
// vnms_ctrl
// Sequencer: coordinate split, border check, sixteen memory reads, pipeline
// drain and result hand-off.
// ----------------------------------------------------------------------------
`include "volume_nonmax_suppression_assert.svh"

module vnms_ctrl
  import vnms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_cmd,
  output logic       in_ready,
  input  dp_status_t stat,
  output ctrl_cmd_t  cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] step_cnt, step_cnt_next;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    state_next    = state;
    step_cnt_next = step_cnt;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_QUERY) begin
            cmd.capture   = 1'b1;
            step_cnt_next = '0;
            state_next    = ST_DIV_X;
          end else begin
            cmd.mem_write = 1'b1;
          end
        end
      end
      ST_DIV_X: begin
        cmd.div_step = 1'b1;
        if (step_cnt == CNT_W'(DIV_LAST)) begin
          cmd.div_load_y = 1'b1;
          step_cnt_next  = '0;
          state_next     = ST_DIV_Y;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_DIV_Y: begin
        cmd.div_step = 1'b1;
        cmd.div_y    = 1'b1;
        if (step_cnt == CNT_W'(DIV_LAST)) begin
          cmd.div_done  = 1'b1;
          step_cnt_next = '0;
          state_next    = ST_CHECK;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_CHECK: begin
        step_cnt_next = '0;
        state_next    = stat.border ? ST_FINISH : ST_READ;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = step_cnt[RD_SEL_W-1:0];
        if (step_cnt == CNT_W'(RD_LAST)) begin
          step_cnt_next = '0;
          state_next    = ST_DRAIN;
        end else begin
          step_cnt_next = step_cnt + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (stat.pipe_idle) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Checks
  `VNMS_ASSERT_SAME(a_publish_free, cmd.publish, stat.out_free, "result published into a full slot")
  `VNMS_ASSERT_NEXT(a_border_skip, (state == ST_CHECK) && stat.border, state == ST_FINISH, "border query did not skip reads")
  `VNMS_ASSERT_NEXT(a_read_done, (state == ST_READ) && (step_cnt == CNT_W'(RD_LAST)), state == ST_DRAIN, "read sweep overran")
  `VNMS_ASSERT_SAME(a_drained, (state == ST_FINISH) && !stat.border, stat.pipe_idle, "finish before pipeline drained")

endmodule

// ===== hdl/vnms_dp.sv =====
// ----------------------------------------------------------------------------
// vnms_dp
// Datapath: size registers, volume memory, serial divider for coordinates,
// neighbor address generation, three-level interpolation pipeline and the
// result register.
// ----------------------------------------------------------------------------
module vnms_dp
  import vnms_pkg::*;
#(
  parameter int unsigned VOLUME_DEPTH   = 262144,
  parameter int unsigned INTENSITY_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [SIZE_W-1:0]           cfg_data,
  input  logic [IDX_W-1:0]            voxel_index,
  input  logic signed [IN_W-1:0]      intensity,
  input  logic signed [NRM_W-1:0]     normal_x,
  input  logic signed [NRM_W-1:0]     normal_y,
  input  logic signed [NRM_W-1:0]     normal_z,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [IDX_W-1:0]            result_index,
  output logic                        is_max,
  output logic                        on_border,
  input  ctrl_cmd_t                   cmd,
  output dp_status_t                  stat
);

  localparam int unsigned AW  = $clog2(VOLUME_DEPTH);
  localparam int unsigned IB  = INTENSITY_BITS;
  localparam int unsigned ACW = ADDR_CALC_W;
  localparam int unsigned PXW = IB + 17;
  localparam int unsigned PYW = PXW + 17;
  localparam int unsigned FW  = PYW - Q_SHIFT;
  localparam int unsigned PZW = FW + 17;
  localparam logic signed [ACW-1:0] ONE_A   = ACW'(1);
  localparam logic signed [ACW-1:0] DEPTH_A = ACW'(VOLUME_DEPTH);

  // Size registers
  logic [SIZE_W-1:0]   size_x, size_y, size_z;
  logic [STRIDE_W-1:0] stride_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x <= clamp_size(cfg_data);
        REG_SIZE_Y: size_y <= clamp_size(cfg_data);
        REG_SIZE_Z: size_z <= clamp_size(cfg_data);
        default: ;
      endcase
    end
  end

  // Slice stride, refreshed every cycle from the sizes
  always_ff @(posedge clk) begin
    stride_xy <= size_x * size_y;
  end

  // Query registers
  logic [IDX_W-1:0]  idx;
  logic              neg_x, neg_y, neg_z;
  logic [15:0]       kx, ky, kz;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx   <= voxel_index;
      neg_x <= normal_x[NRM_W-1];
      neg_y <= normal_y[NRM_W-1];
      neg_z <= normal_z[NRM_W-1];
      kx    <= weight_q15(normal_x);
      ky    <= weight_q15(normal_y);
      kz    <= weight_q15(normal_z);
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [SIZE_W-1:0] rem, div_sor, div_rem_next;
  logic [IDX_W-1:0]  quo, div_quo_next;
  logic [SIZE_W:0]   div_shift, div_diff;
  logic              div_ge;
  logic [SIZE_W-1:0] crd_x, crd_y;
  logic [IDX_W-1:0]  crd_z;

  always_comb begin
    div_sor      = cmd.div_y ? size_y : size_x;
    div_shift    = {rem, quo[IDX_W-1]};
    div_ge       = div_shift >= {1'b0, div_sor};
    div_diff     = div_shift - {1'b0, div_sor};
    div_rem_next = div_ge ? div_diff[SIZE_W-1:0] : div_shift[SIZE_W-1:0];
    div_quo_next = {quo[IDX_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rem <= '0;
      quo <= voxel_index;
    end else if (cmd.div_step) begin
      if (cmd.div_load_y) begin
        crd_x <= div_rem_next;
        quo   <= div_quo_next;
        rem   <= '0;
      end else if (cmd.div_done) begin
        crd_y <= div_rem_next;
        crd_z <= div_quo_next;
      end else begin
        rem <= div_rem_next;
        quo <= div_quo_next;
      end
    end
  end

  // Border test on the split coordinates
  logic border;

  always_comb begin
    border = (crd_z >= IDX_W'(size_z)) || (crd_x == '0) || (crd_y == '0) ||
             (crd_z == '0) || (crd_x == size_x - 1'b1) || (crd_y == size_y - 1'b1) ||
             (crd_z == IDX_W'(size_z - 1'b1));
  end

  // Neighbor address: corner {dz,dy,dx} of the forward or mirrored cell
  logic                   sx_neg, sy_neg, sz_neg;
  logic signed [ACW-1:0]  off_x, off_y, off_z, rd_addr;
  logic                   rd_inr, ld_inr;
  logic [AW-1:0]          mem_addr;

  always_comb begin
    sx_neg  = neg_x ^ cmd.rd_sel[3];
    sy_neg  = neg_y ^ cmd.rd_sel[3];
    sz_neg  = neg_z ^ cmd.rd_sel[3];
    off_x   = '0;
    off_y   = '0;
    off_z   = '0;
    if (cmd.rd_sel[0]) off_x = sx_neg ? -ONE_A : ONE_A;
    if (cmd.rd_sel[1]) off_y = sy_neg ? -$signed(ACW'(size_x)) : $signed(ACW'(size_x));
    if (cmd.rd_sel[2]) off_z = sz_neg ? -$signed(ACW'(stride_xy)) : $signed(ACW'(stride_xy));
    rd_addr  = $signed(ACW'(idx)) + off_x + off_y + off_z;
    rd_inr   = (rd_addr >= 0) && (rd_addr < DEPTH_A);
    ld_inr   = $signed(ACW'(voxel_index)) < DEPTH_A;
    mem_addr = cmd.mem_write ? AW'(voxel_index) : rd_addr[AW-1:0];
  end

  // Volume memory, single port, registered read
  logic signed [IB-1:0] vol_mem [VOLUME_DEPTH];
  logic signed [IB-1:0] rdata;

  always_ff @(posedge clk) begin
    if (cmd.mem_write && ld_inr) vol_mem[mem_addr] <= IB'(intensity);
    if (cmd.rd_en) rdata <= vol_mem[mem_addr];
  end

  // Pipeline tags
  tap_t s0, s1, s2, s3, s4, s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0 <= '0;
      s1 <= '0;
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
      s5 <= '0;
    end else begin
      s0 <= '{v: cmd.rd_en, dir: cmd.rd_sel[3], dz: cmd.rd_sel[2],
              dy: cmd.rd_sel[1], dx: cmd.rd_sel[0], inr: rd_inr};
      s1 <= s0;
      s2 <= '{v: s1.v & s1.dx, dir: s1.dir, dz: s1.dz,
              dy: s1.dy, dx: s1.dx, inr: s1.inr};
      s3 <= s2;
      s4 <= '{v: s3.v & s3.dy, dir: s3.dir, dz: s3.dz,
              dy: s3.dy, dx: s3.dx, inr: s3.inr};
      s5 <= s4;
    end
  end

  // Interpolation datapath: x lerp, y lerp with floor, z lerp, compare
  logic signed [IB-1:0]  cval, centre;
  logic signed [PXW-1:0] px, ax, e;
  logic signed [PYW-1:0] py, ay, ysum;
  logic signed [FW-1:0]  f;
  logic signed [PZW-1:0] pz, az, zsum, centre_q;
  logic                  max_ok;

  always_comb begin
    cval     = s0.inr ? rdata : '0;
    ysum     = ay + py;
    zsum     = az + pz;
    centre_q = PZW'(centre) <<< CENTRE_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (s0.v && !s0.dir && !s0.dz && !s0.dy && !s0.dx) centre <= cval;
    px <= cval * lerp_w(s0.dx, kx);
    if (s1.v) begin
      if (s1.dx) e <= ax + px;
      else       ax <= px;
    end
    py <= e * lerp_w(s2.dy, ky);
    if (s3.v) begin
      if (s3.dy) f <= ysum[PYW-1:Q_SHIFT];
      else       ay <= py;
    end
    pz <= f * lerp_w(s4.dz, kz);
    if (s5.v && !s5.dz) az <= pz;
  end

  // Maximum flag: clear when either interpolated neighbor reaches the centre
  always_ff @(posedge clk) begin
    if (cmd.capture) max_ok <= 1'b1;
    else if (s5.v && s5.dz && !(centre_q > zsum)) max_ok <= 1'b0;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result_index <= idx;
      is_max       <= !border && max_ok;
      on_border    <= border;
    end
  end

  // Status
  always_comb begin
    stat.border    = border;
    stat.pipe_idle = !(s0.v || s1.v || s2.v || s3.v || s4.v || s5.v);
    stat.out_free  = !out_valid || out_ready;
  end

endmodule

// ===== hdl/volume_nonmax_suppression.sv =====
// ----------------------------------------------------------------------------
// volume_nonmax_suppression
// Non-maximum suppression along a normal vector in a 3-D intensity volume.
// ----------------------------------------------------------------------------
// A load item (cmd 0) writes one intensity and is taken while the block is
// idle. A query item (cmd 1) returns one result: the voxel index, a border
// flag, and is_max when the voxel is off the border and the centre strictly
// exceeds the trilinear values one step forward and one step backward along
// the normal's sign octant. A query runs a bit-serial divider to split the
// index into x, y, z, then a border check, then sixteen reads of the
// single-port volume memory (one read per cycle) and a drain of the
// interpolation pipeline; a border query skips the reads and the drain.
// The next item is taken once the current query sits in the output register,
// even if not yet taken downstream. Sizes are to be written by the user only
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module volume_nonmax_suppression
  import vnms_pkg::*;
#(
  parameter int unsigned VOLUME_DEPTH   = 262144,
  parameter int unsigned INTENSITY_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SIZE_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    cmd,
  input  logic [IDX_W-1:0]        voxel_index,
  input  logic signed [IN_W-1:0]  intensity,
  input  logic signed [NRM_W-1:0] normal_x,
  input  logic signed [NRM_W-1:0] normal_y,
  input  logic signed [NRM_W-1:0] normal_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        result_index,
  output logic                    is_max,
  output logic                    on_border
);

  ctrl_cmd_t  ctl_cmd;
  dp_status_t dp_stat;

  // Sequencer
  vnms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  // Datapath
  vnms_dp #(
    .VOLUME_DEPTH   (VOLUME_DEPTH),
    .INTENSITY_BITS (INTENSITY_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .voxel_index  (voxel_index),
    .intensity    (intensity),
    .normal_x     (normal_x),
    .normal_y     (normal_y),
    .normal_z     (normal_z),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .result_index (result_index),
    .is_max       (is_max),
    .on_border    (on_border),
    .cmd          (ctl_cmd),
    .stat         (dp_stat)
  );

endmodule
